@@ rtl/msl_pkg.sv @@
package msl_pkg;

   localparam int MOTOR_COUNT     = 4;
   localparam int MOTOR_IDX_WIDTH = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   localparam int TIME_WIDTH    = 63;
   localparam int CMD_WIDTH     = 15;
   localparam int DRIVE_WIDTH   = 14;
   localparam int SPIN_WIDTH    = 14;
   localparam int SPAN_WIDTH    = 24;
   localparam int PRODUCT_WIDTH = DRIVE_WIDTH + SPAN_WIDTH;

   localparam logic [DRIVE_WIDTH-1:0] FULL_SCALE = DRIVE_WIDTH'(10000);

   localparam int REQ_FIELD_BITS = 2 * TIME_WIDTH + MOTOR_COUNT * CMD_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = TIME_WIDTH + MOTOR_COUNT * DRIVE_WIDTH + MOTOR_COUNT;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_SPIN_MINIMUM = 2'd0;
   localparam logic [1:0] REG_RAMP_TIME    = 2'd1;
   localparam logic [1:0] REG_HOLD_TIME    = 2'd2;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] now_time;
      logic [TIME_WIDTH-1:0] start_time;
      logic [SPIN_WIDTH-1:0] spin_minimum;
      logic [SPAN_WIDTH-1:0] ramp_time;
      logic [SPAN_WIDTH-1:0] hold_time;
   } cap_req_type;

   typedef struct packed {
      logic                   done;
      logic [DRIVE_WIDTH-1:0] cap;
   } cap_rsp_type;

endpackage

@@ rtl/motor_soft_start_limiter.sv @@
// Per request the sequencer walks the motors in order: a stopped motor is settled in
// S_MOTOR, any other waits in S_WAIT for the cap unit, and S_OUT then loads the result.
// A new request is taken only once the result is loaded, and S_OUT holds while the
// output is stalled; the shared 14-step radix-2 divider that scales the ramp is the
// slowest step. Reset is synchronous: the configuration registers read zero, all motors
// are stopped, and the block takes a request in the first cycle after reset.
module motor_soft_start_limiter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // stamp_in[62:0], now_time[125:63], request_a..request_d 15 bits each from bit 126
   input  logic [msl_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // stamp_out[62:0], drive_a..drive_d 14 bits each from bit 63, started_mask[122:119]
   output logic [msl_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [msl_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [msl_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [msl_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import msl_pkg::*;

   localparam int CMD_LSB     = 2 * TIME_WIDTH;
   localparam int DRIVE_LSB   = TIME_WIDTH;
   localparam int STARTED_LSB = TIME_WIDTH + MOTOR_COUNT * DRIVE_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOTOR,
      S_WAIT,
      S_OUT
   } top_state_type;

   top_state_type              state_ff, state_in;
   logic [MOTOR_IDX_WIDTH-1:0] motor_ff, motor_in;
   logic [MOTOR_COUNT-1:0]     running_ff, running_in;
   logic [MOTOR_COUNT-1:0]     started_ff, started_in;
   logic [TIME_WIDTH-1:0]      start_time_ff [MOTOR_COUNT];
   logic [TIME_WIDTH-1:0]      start_time_in [MOTOR_COUNT];
   logic [TIME_WIDTH-1:0]      stamp_ff, stamp_in;
   logic [TIME_WIDTH-1:0]      now_ff, now_in;
   logic [CMD_WIDTH-1:0]       cmd_ff [MOTOR_COUNT];
   logic [CMD_WIDTH-1:0]       cmd_in [MOTOR_COUNT];
   logic [DRIVE_WIDTH-1:0]     drive_ff [MOTOR_COUNT];
   logic [DRIVE_WIDTH-1:0]     drive_in [MOTOR_COUNT];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic [SPIN_WIDTH-1:0]      spin_minimum_ff, spin_minimum_in;
   logic [SPAN_WIDTH-1:0]      ramp_time_ff, ramp_time_in;
   logic [SPAN_WIDTH-1:0]      hold_time_ff, hold_time_in;

   logic                       req_accept;
   logic                       csr_write;
   logic [1:0]                 csr_index;
   logic [CMD_WIDTH-1:0]       cmd_sel;
   logic [DRIVE_WIDTH-1:0]     cmd_mag;
   logic                       cmd_stop;
   logic                       last_motor;
   logic                       cap_start;
   cap_req_type                cap_req;
   cap_rsp_type                cap_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cmd_sel    = cmd_ff[motor_ff];
   assign cmd_mag    = cmd_sel[DRIVE_WIDTH-1:0];
   assign cmd_stop   = (cmd_sel == '0) || cmd_sel[CMD_WIDTH-1];
   assign last_motor = (motor_ff == MOTOR_IDX_WIDTH'(MOTOR_COUNT - 1));

   // Configuration port: software must write it only while the block is idle; the block itself does not enforce this.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      spin_minimum_in = spin_minimum_ff;
      ramp_time_in    = ramp_time_ff;
      hold_time_in    = hold_time_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SPIN_MINIMUM: spin_minimum_in = csr_pwdata[SPIN_WIDTH-1:0];
            REG_RAMP_TIME:    ramp_time_in    = csr_pwdata[SPAN_WIDTH-1:0];
            REG_HOLD_TIME:    hold_time_in    = csr_pwdata[SPAN_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SPIN_MINIMUM: csr_prdata = CSR_DATA_WIDTH'(spin_minimum_ff);
         REG_RAMP_TIME:    csr_prdata = CSR_DATA_WIDTH'(ramp_time_ff);
         REG_HOLD_TIME:    csr_prdata = CSR_DATA_WIDTH'(hold_time_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // A motor that starts on this request measures its cap from the current time.
   always_comb begin
      cap_req.now_time     = now_ff;
      cap_req.start_time   = running_ff[motor_ff] ? start_time_ff[motor_ff] : now_ff;
      cap_req.spin_minimum = spin_minimum_ff;
      cap_req.ramp_time    = ramp_time_ff;
      cap_req.hold_time    = hold_time_ff;
   end

   always_comb begin
      state_in      = state_ff;
      motor_in      = motor_ff;
      running_in    = running_ff;
      started_in    = started_ff;
      start_time_in = start_time_ff;
      stamp_in      = stamp_ff;
      now_in        = now_ff;
      cmd_in        = cmd_ff;
      drive_in      = drive_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      cap_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               stamp_in = req_tdata[TIME_WIDTH-1:0];
               now_in   = req_tdata[2*TIME_WIDTH-1:TIME_WIDTH];
               for (int i = 0; i < MOTOR_COUNT; i++) begin
                  cmd_in[i] = req_tdata[CMD_LSB + i*CMD_WIDTH +: CMD_WIDTH];
               end
               motor_in   = '0;
               started_in = '0;
               state_in   = S_MOTOR;
            end
         end
         S_MOTOR: begin
            if (cmd_stop) begin
               running_in[motor_ff] = 1'b0;
               drive_in[motor_ff]   = '0;
               motor_in             = motor_ff + MOTOR_IDX_WIDTH'(1);
               state_in             = last_motor ? S_OUT : S_MOTOR;
            end else begin
               if (!running_ff[motor_ff]) begin
                  running_in[motor_ff]    = 1'b1;
                  started_in[motor_ff]    = 1'b1;
                  start_time_in[motor_ff] = now_ff;
               end
               cap_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (cap_rsp.done) begin
               drive_in[motor_ff] = (cmd_mag < cap_rsp.cap) ? cmd_mag : cap_rsp.cap;
               motor_in           = motor_ff + MOTOR_IDX_WIDTH'(1);
               state_in           = last_motor ? S_OUT : S_MOTOR;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in                 = '0;
               rsp_data_in[TIME_WIDTH-1:0] = stamp_ff;
               for (int i = 0; i < MOTOR_COUNT; i++) begin
                  rsp_data_in[DRIVE_LSB + i*DRIVE_WIDTH +: DRIVE_WIDTH] = drive_ff[i];
               end
               rsp_data_in[STARTED_LSB +: MOTOR_COUNT] = started_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         motor_ff        <= '0;
         running_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         spin_minimum_ff <= '0;
         ramp_time_ff    <= '0;
         hold_time_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         motor_ff        <= motor_in;
         running_ff      <= running_in;
         rsp_valid_ff    <= rsp_valid_in;
         spin_minimum_ff <= spin_minimum_in;
         ramp_time_ff    <= ramp_time_in;
         hold_time_ff    <= hold_time_in;
      end
      started_ff    <= started_in;
      start_time_ff <= start_time_in;
      stamp_ff      <= stamp_in;
      now_ff        <= now_in;
      cmd_ff        <= cmd_in;
      drive_ff      <= drive_in;
      rsp_data_ff   <= rsp_data_in;
   end

   msl_cap u_cap (
      .clock (clock),
      .reset (reset),
      .start (cap_start),
      .req   (cap_req),
      .rsp   (cap_rsp)
   );

`ifndef NO_ASSERTIONS
   // Every drive in a result is bounded by full scale, since the cap never exceeds it.
   a_drive_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DRIVE_LSB +: DRIVE_WIDTH] <= FULL_SCALE)
         && (rsp_tdata[DRIVE_LSB + DRIVE_WIDTH +: DRIVE_WIDTH] <= FULL_SCALE)
         && (rsp_tdata[DRIVE_LSB + 2*DRIVE_WIDTH +: DRIVE_WIDTH] <= FULL_SCALE)
         && (rsp_tdata[DRIVE_LSB + 3*DRIVE_WIDTH +: DRIVE_WIDTH] <= FULL_SCALE))
      else $error("drive above full scale");

   // The cap unit only finishes while the sequencer is waiting for it.
   a_cap_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cap_rsp.done |-> (state_ff == S_WAIT))
      else $error("cap result arrived outside of wait");

   // A cap request is never issued while a previous one is still in flight.
   a_cap_start_waits: assert property (@(posedge clock) disable iff (reset)
      cap_start |=> (state_ff == S_WAIT) && !cap_rsp.done)
      else $error("cap request overlapped");

   // Once results are loaded, the output register holds a valid result.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready)
         |=> rsp_tvalid && (state_ff == S_IDLE))
      else $error("result not loaded");
`endif

endmodule

@@ rtl/msl_div.sv @@
module msl_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [msl_pkg::PRODUCT_WIDTH-1:0] dividend,
   input  logic [msl_pkg::SPAN_WIDTH-1:0]    divisor,
   output logic                              done,
   output logic [msl_pkg::DRIVE_WIDTH-1:0]   quotient
);
   import msl_pkg::*;

   localparam int COUNT_WIDTH = $clog2(DRIVE_WIDTH);

   typedef enum logic {
      D_IDLE,
      D_RUN
   } div_state_type;

   div_state_type          state_ff, state_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [SPAN_WIDTH-1:0]  rem_ff, rem_in;
   logic [DRIVE_WIDTH-1:0] digits_ff, digits_in;
   logic [SPAN_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [SPAN_WIDTH:0]    shifted;
   logic [SPAN_WIDTH+1:0]  trial;
   logic                   fits;

   // The quotient is known to stay below 2**DRIVE_WIDTH, so the upper part of
   // the dividend is already a valid partial remainder and only DRIVE_WIDTH
   // quotient bits are developed, one per cycle. They shift into the low end
   // of the same register that feeds the dividend bits out of its top.
   assign shifted = {rem_ff, digits_ff[DRIVE_WIDTH-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor_ff};
   assign fits    = ~trial[SPAN_WIDTH+1];

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      digits_in  = digits_ff;
      divisor_in = divisor_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in     = dividend[PRODUCT_WIDTH-1:DRIVE_WIDTH];
               digits_in  = dividend[DRIVE_WIDTH-1:0];
               divisor_in = divisor;
               count_in   = '0;
               state_in   = D_RUN;
            end
         end
         D_RUN: begin
            rem_in    = fits ? trial[SPAN_WIDTH-1:0] : shifted[SPAN_WIDTH-1:0];
            digits_in = {digits_ff[DRIVE_WIDTH-2:0], fits};
            count_in  = count_ff + COUNT_WIDTH'(1);
            if (count_ff == COUNT_WIDTH'(DRIVE_WIDTH - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      digits_ff  <= digits_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = digits_ff;

endmodule

@@ rtl/msl_cap.sv @@
module msl_cap (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  msl_pkg::cap_req_type req,
   output msl_pkg::cap_rsp_type rsp
);
   import msl_pkg::*;

   typedef enum logic [1:0] {
      C_IDLE,
      C_CMP,
      C_LAUNCH,
      C_DIV
   } cap_state_type;

   cap_state_type            state_ff, state_in;
   logic                     done_ff, done_in;
   logic [DRIVE_WIDTH-1:0]   cap_ff, cap_in;
   logic [TIME_WIDTH-1:0]    el_ff, el_in;
   logic                     back_ff, back_in;
   logic [DRIVE_WIDTH-1:0]   top_ff, top_in;
   logic [SPAN_WIDTH-1:0]    ramp_ff, ramp_in;
   logic [SPAN_WIDTH-1:0]    hold_ff, hold_in;
   logic [PRODUCT_WIDTH-1:0] product_ff, product_in;

   logic [TIME_WIDTH:0]      diff;
   logic [SPAN_WIDTH:0]      hold_end;
   logic                     in_ramp;
   logic                     in_hold;
   logic                     div_start;
   logic                     div_done;
   logic [DRIVE_WIDTH-1:0]   quotient;

   assign diff     = {1'b0, req.now_time} - {1'b0, req.start_time};
   assign hold_end = {1'b0, ramp_ff} + {1'b0, hold_ff};
   assign in_ramp  = (el_ff[TIME_WIDTH-1:SPAN_WIDTH] == '0)
                     && (el_ff[SPAN_WIDTH-1:0] < ramp_ff);
   assign in_hold  = (el_ff[TIME_WIDTH-1:SPAN_WIDTH+1] == '0)
                     && (el_ff[SPAN_WIDTH:0] < hold_end);
   assign div_start = (state_ff == C_LAUNCH);

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      cap_in     = cap_ff;
      el_in      = el_ff;
      back_in    = back_ff;
      top_in     = top_ff;
      ramp_in    = ramp_ff;
      hold_in    = hold_ff;
      product_in = product_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               el_in    = diff[TIME_WIDTH-1:0];
               back_in  = diff[TIME_WIDTH];
               top_in   = (req.spin_minimum > FULL_SCALE) ? FULL_SCALE : req.spin_minimum;
               ramp_in  = req.ramp_time;
               hold_in  = req.hold_time;
               state_in = C_CMP;
            end
         end
         C_CMP: begin
            product_in = PRODUCT_WIDTH'(top_ff) * PRODUCT_WIDTH'(el_ff[SPAN_WIDTH-1:0]);
            if (back_ff) begin
               cap_in   = '0;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else if (in_ramp) begin
               state_in = C_LAUNCH;
            end else if (in_hold) begin
               cap_in   = top_ff;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               cap_in   = FULL_SCALE;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         C_LAUNCH: begin
            state_in = C_DIV;
         end
         C_DIV: begin
            if (div_done) begin
               cap_in   = quotient;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cap_ff     <= cap_in;
      el_ff      <= el_in;
      back_ff    <= back_in;
      top_ff     <= top_in;
      ramp_ff    <= ramp_in;
      hold_ff    <= hold_in;
      product_ff <= product_in;
   end

   msl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (ramp_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp.done = done_ff;
   assign rsp.cap  = cap_ff;

endmodule
